// ===== sv/b2da_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W         = 32;
    localparam int DIGITS          = 10;
    localparam int BCD_W           = 4 * DIGITS;
    localparam int CHAR_W          = 6;
    localparam int STAGES          = 4;
    localparam int STEPS_PER_STAGE = VALUE_W / STAGES;
    localparam int IDX_W           = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 6'd32;

    // Position of the trailing space in the character stream.
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(DIGITS);

    typedef logic [BCD_W-1:0]   bcd_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]  char_t;

endpackage

`default_nettype wire

// ===== sv/b2da_dabble.sv =====
// One pipeline slice of the shift-and-add-3 binary to BCD conversion.
`default_nettype none

module b2da_dabble
    import b2da_pkg::*;
(
    input  bcd_t   bcd_in,
    input  value_t bin_in,
    output bcd_t   bcd_out,
    output value_t bin_out
);

    always_comb
    begin
        bcd_t   bcd;
        value_t bin;
        bcd = bcd_in;
        bin = bin_in;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            // Correct every digit that would pass nine after the shift.
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd[4*d +: 4] >= 4'd5)
                begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
            bin = {bin[VALUE_W-2:0], 1'b0};
        end
        bcd_out = bcd;
        bin_out = bin;
    end

endmodule

`default_nettype wire

// ===== sv/binary_to_decimal_ascii_top.sv =====
// Top level of the 32-bit binary to decimal ASCII converter.
//
// Each request on the value channel carries one unsigned 32-bit number; the
// block answers with eleven characters on the character channel: the ten
// decimal digits, most significant first with leading zeros kept, and then a
// space with last set. The conversion runs through a four-stage shift-and-
// add-3 pipeline (eight bit steps per stage) that takes a new request every
// cycle while value_stall is low, then a one-entry serializer buffer and an
// output register. The character channel moves one character per cycle while
// char_stall is low; the pipeline stages absorb up to four more requests
// while the serializer is busy. A request passes the stage registers, then
// the serializer buffer, then the output register. value_stall rises once
// every stage is full and the serializer cannot drain the last stage.
`default_nettype none

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,

    input  wire logic   value_valid,
    output logic        value_stall,
    input  wire value_t value,

    output logic        char_valid,
    input  wire logic   char_stall,
    output char_t       character,
    output logic        last
);

    // Conversion pipeline.
    logic   [STAGES-1:0] vld_reg;
    bcd_t                bcd_reg [STAGES];
    value_t              bin_reg [STAGES];

    bcd_t                bcd_comb [STAGES];
    value_t              bin_comb [STAGES];

    logic   [STAGES-1:0] can_take;
    logic   [STAGES-1:0] moves_out;

    // Serializer buffer and output register.
    logic                buf_vld_reg;
    bcd_t                buf_bcd_reg;
    logic   [IDX_W-1:0]  idx_reg;
    logic                buf_can_take;
    logic                buf_done;
    logic                out_can_load;
    logic                emit;

    logic                out_valid_reg;
    char_t               out_char_reg;
    logic                out_last_reg;

    // Combinational slices between the stage registers.
    for (genvar g = 0; g < STAGES; g++)
    begin : g_slice
        if (g == 0)
        begin : g_first
            b2da_dabble u_dabble
            (
                .bcd_in  ('0),
                .bin_in  (value),
                .bcd_out (bcd_comb[g]),
                .bin_out (bin_comb[g])
            );
        end
        else
        begin : g_rest
            b2da_dabble u_dabble
            (
                .bcd_in  (bcd_reg[g-1]),
                .bin_in  (bin_reg[g-1]),
                .bcd_out (bcd_comb[g]),
                .bin_out (bin_comb[g])
            );
        end
    end

    // Output register frees when empty or when its character is taken.
    assign out_can_load = !out_valid_reg || !char_stall;
    assign emit         = buf_vld_reg && out_can_load;
    assign buf_done     = emit && (idx_reg == LAST_INDEX);
    assign buf_can_take = !buf_vld_reg || buf_done;

    // Advance chain, walked from the serializer back to the input.
    always_comb
    begin
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            if (i == STAGES - 1)
            begin
                moves_out[i] = vld_reg[i] && buf_can_take;
            end
            else
            begin
                moves_out[i] = vld_reg[i] && can_take[i+1];
            end
            can_take[i] = !vld_reg[i] || moves_out[i];
        end
    end

    assign value_stall = !can_take[0];

    // Valid bits of the pipeline stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (can_take[i])
                begin
                    vld_reg[i] <= (i == 0) ? value_valid : vld_reg[i-1];
                end
            end
        end
    end

    // Payload of the pipeline stages; load only real requests.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STAGES; i++)
        begin
            if (can_take[i] && ((i == 0) ? value_valid : vld_reg[i-1]))
            begin
                bcd_reg[i] <= bcd_comb[i];
                bin_reg[i] <= bin_comb[i];
            end
        end
    end

    // Serializer: hold one converted request, shift out a digit per emit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else if (moves_out[STAGES-1])
        begin
            buf_vld_reg <= 1'b1;
            idx_reg     <= '0;
        end
        else if (buf_done)
        begin
            buf_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (moves_out[STAGES-1])
        begin
            buf_bcd_reg <= bcd_reg[STAGES-1];
        end
        else if (emit)
        begin
            buf_bcd_reg <= {buf_bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    // Output register: drop valid once taken, refill from the serializer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (out_can_load)
        begin
            out_valid_reg <= emit;
            out_last_reg  <= emit && (idx_reg == LAST_INDEX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (idx_reg == LAST_INDEX)
            begin
                out_char_reg <= ASCII_SPACE;
            end
            else
            begin
                out_char_reg <= ASCII_ZERO + CHAR_W'(buf_bcd_reg[BCD_W-1 -: 4]);
            end
        end
    end

    assign char_valid = out_valid_reg;
    assign character  = out_char_reg;
    assign last       = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/b2da_checker.sv =====
// Port-level checker for the binary to decimal ASCII converter, with its bind.
`default_nettype none

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   value_valid,
    input wire logic   value_stall,
    input wire value_t value,
    input wire logic   char_valid,
    input wire logic   char_stall,
    input wire char_t  character,
    input wire logic   last
);

    // A stalled character request holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(character) && $stable(last))
        else $error("character request changed while stalled");

    // The closing character is always a space.
    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last |-> character == ASCII_SPACE)
        else $error("last character is not a space");

    // Every other character is a decimal digit.
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !last |-> character >= ASCII_ZERO && character <= (ASCII_ZERO + 6'd9))
        else $error("digit character out of range");

    // A stall on the input only follows backed-up work behind it.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(value_stall) |-> $past(value_valid) || $past(value_stall) || char_valid)
        else $error("input stalled with nothing in flight");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (.*);

`default_nettype wire
